// ===== src/scp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and constants of the surface code CNOT partner lookup.
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int MaxDistance = 31;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_DISTANCE  = 2'd2,
        ST_RESERVED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        QC_DATA = 2'd0,
        QC_XANC = 2'd1,
        QC_ZANC = 2'd2,
        QC_NONE = 2'd3
    } qclass_t;

    // Values derived from the code distance, held next to the register.
    typedef struct packed {
        logic [4:0]  d;
        logic [9:0]  dd;
        logic [8:0]  hx;
        logic [3:0]  h;
        logic [10:0] lim;
        logic        bad;
        logic [16:0] rd;
        logic [16:0] rd1;
        logic [16:0] rh;
    } cfg_t;

    // Reciprocals floor(2^16 / n) + 1, exact for dividends below 2048.
    localparam logic [16:0] RECIP_TBL [0:32] = '{
        17'd0,     17'd65537, 17'd32769, 17'd21846, 17'd16385, 17'd13108,
        17'd10923, 17'd9363,  17'd8193,  17'd7282,  17'd6554,  17'd5958,
        17'd5462,  17'd5042,  17'd4682,  17'd4370,  17'd4097,  17'd3856,
        17'd3641,  17'd3450,  17'd3277,  17'd3121,  17'd2979,  17'd2850,
        17'd2731,  17'd2622,  17'd2521,  17'd2428,  17'd2341,  17'd2260,
        17'd2185,  17'd2115,  17'd2049
    };

endpackage

// ===== src/scp_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_cfg
// Code distance register and the values derived from it.
// ----------------------------------------------------------------------------
module scp_cfg
    import scp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_en,
    input  logic [4:0] wr_data,
    output cfg_t       cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;

    function automatic cfg_t derive(input logic [4:0] d);
        cfg_t       c;
        logic [9:0] sq;
        sq       = 10'(d * d);
        c.d      = d;
        c.dd     = sq;
        c.hx     = 9'((sq - 10'd1) >> 1);
        c.h      = 4'((d - 5'd1) >> 1);
        c.lim    = 11'({sq, 1'b0} - 11'd1);
        c.bad    = (d < 5'd3) || !d[0];
        c.rd     = RECIP_TBL[{1'b0, d}];
        c.rd1    = RECIP_TBL[6'({1'b0, d} + 6'd1)];
        c.rh     = RECIP_TBL[{2'b00, c.h}];
        return c;
    endfunction

    assign cfg_next = derive(wr_data);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= derive(5'd3);
        end else if (wr_en) begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/scp_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_decode
// Three stages: classify the index, divide by reciprocal, form coordinates.
// ----------------------------------------------------------------------------
module scp_decode
    import scp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  cfg_t        cfg,
    input  logic        in_valid,
    input  logic [1:0]  in_step,
    input  logic [10:0] in_qubit,
    output logic        out_valid,
    output status_t     out_status,
    output qclass_t     out_cls,
    output logic [1:0]  out_step,
    output logic [5:0]  out_x,
    output logic [5:0]  out_y
);

    logic        v1_reg, v2_reg, v3_reg;
    status_t     st1_reg, st2_reg, st3_reg;
    qclass_t     cl1_reg, cl2_reg, cl3_reg;
    logic [1:0]  sp1_reg, sp2_reg, sp3_reg;
    logic [9:0]  r1_reg, r2_reg;
    logic [16:0] rc1_reg;
    logic [5:0]  dv1_reg, dv2_reg;
    logic [9:0]  quo2_reg;
    logic [5:0]  x3_reg, y3_reg;

    status_t     st1_next;
    qclass_t     cl1_next;
    logic [9:0]  r1_next;
    logic [16:0] rc1_next;
    logic [5:0]  dv1_next;
    logic [26:0] prod2;
    logic [15:0] back3;
    logic [4:0]  rem3;
    logic [5:0]  x3_next, y3_next;

    always_comb begin
        st1_next = ST_OK;
        if (cfg.bad) begin
            st1_next = ST_DISTANCE;
        end else if (in_qubit >= cfg.lim) begin
            st1_next = ST_RANGE;
        end
        if (in_qubit < {1'b0, cfg.dd}) begin
            cl1_next = QC_DATA;
            r1_next  = in_qubit[9:0];
            rc1_next = cfg.rd;
            dv1_next = {1'b0, cfg.d};
        end else if (in_qubit < 11'({1'b0, cfg.dd} + {2'b00, cfg.hx})) begin
            cl1_next = QC_XANC;
            r1_next  = 10'(in_qubit - {1'b0, cfg.dd});
            rc1_next = cfg.rd1;
            dv1_next = 6'({1'b0, cfg.d} + 6'd1);
        end else begin
            cl1_next = QC_ZANC;
            r1_next  = 10'(in_qubit - {1'b0, cfg.dd} - {2'b00, cfg.hx});
            rc1_next = cfg.rh;
            dv1_next = {2'b00, cfg.h};
        end
    end

    assign prod2 = 27'(r1_reg * rc1_reg);
    assign back3 = 16'(quo2_reg * dv2_reg);
    assign rem3  = 5'(r2_reg - back3[9:0]);

    always_comb begin
        case (cl2_reg)
            QC_DATA: begin
                x3_next = 6'({quo2_reg, 1'b1});
                y3_next = {rem3, 1'b1};
            end
            QC_XANC: begin
                y3_next = {rem3, 1'b0};
                x3_next = 6'({quo2_reg, 2'b10} + (rem3[0] ? 12'd0 : 12'd2));
            end
            QC_ZANC: begin
                x3_next = 6'({quo2_reg, 1'b0});
                y3_next = 6'({rem3, 2'b10} + (quo2_reg[0] ? 7'd2 : 7'd0));
            end
            default: begin
                x3_next = '0;
                y3_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st1_reg  <= st1_next;
            cl1_reg  <= cl1_next;
            sp1_reg  <= in_step;
            r1_reg   <= r1_next;
            rc1_reg  <= rc1_next;
            dv1_reg  <= dv1_next;
            st2_reg  <= st1_reg;
            cl2_reg  <= cl1_reg;
            sp2_reg  <= sp1_reg;
            r2_reg   <= r1_reg;
            dv2_reg  <= dv1_reg;
            quo2_reg <= prod2[25:16];
            st3_reg  <= st2_reg;
            cl3_reg  <= cl2_reg;
            sp3_reg  <= sp2_reg;
            x3_reg   <= x3_next;
            y3_reg   <= y3_next;
        end
    end

    assign out_valid  = v3_reg;
    assign out_status = st3_reg;
    assign out_cls    = cl3_reg;
    assign out_step   = sp3_reg;
    assign out_x      = x3_reg;
    assign out_y      = y3_reg;

endmodule

// ===== src/scp_partner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_partner
// Two stages: find the neighbor on the lattice, then form its index.
// ----------------------------------------------------------------------------
module scp_partner
    import scp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  cfg_t        cfg,
    input  logic        in_valid,
    input  status_t     in_status,
    input  qclass_t     in_cls,
    input  logic [1:0]  in_step,
    input  logic [5:0]  in_x,
    input  logic [5:0]  in_y,
    output logic        out_valid,
    output logic [1:0]  out_status,
    output logic [5:0]  out_x,
    output logic [5:0]  out_y,
    output logic        out_has,
    output logic [10:0] out_partner,
    output logic        out_ctl
);

    logic        v4_reg, v5_reg;
    status_t     st4_reg;
    logic [5:0]  x4_reg, y4_reg;
    logic        has4_reg, ctl4_reg;
    logic [10:0] base4_reg;
    logic [4:0]  ma4_reg;
    logic [5:0]  mb4_reg;
    logic [4:0]  ad4_reg;
    logic [1:0]  st5_reg;
    logic [5:0]  x5_reg, y5_reg;
    logic        has5_reg, ctl5_reg;
    logic [10:0] p5_reg;

    logic signed [7:0] sx, sy, d2;
    logic signed [7:0] xdx, xdy, zdx, zdy;
    logic signed [7:0] zcx, zcy, xcx, xcy, dcx, dcy;
    logic signed [7:0] zu, xu;
    logic        zv, xv, dv;
    logic        has4_next, ctl4_next;
    logic [10:0] base4_next;
    logic [4:0]  ma4_next;
    logic [5:0]  mb4_next;
    logic [4:0]  ad4_next;
    logic [10:0] p5_next;

    always_comb begin
        sx  = $signed({2'b00, in_x});
        sy  = $signed({2'b00, in_y});
        d2  = $signed({2'b00, cfg.d, 1'b0});
        xdx = in_step[0] ? 8'sd1 : -8'sd1;
        xdy = in_step[1] ? -8'sd1 : 8'sd1;
        zdx = in_step[1] ? 8'sd1 : -8'sd1;
        zdy = in_step[0] ? -8'sd1 : 8'sd1;
        zcx = sx - zdx;
        zcy = sy - zdy;
        xcx = sx - xdx;
        xcy = sy - xdy;
        if (in_cls == QC_XANC) begin
            dcx = sx + xdx;
            dcy = sy + xdy;
        end else begin
            dcx = sx + zdx;
            dcy = sy + zdy;
        end

        zu = zcy - 8'sd2 - (zcx[1] ? 8'sd2 : 8'sd0);
        zv = (zcx >= 0) && (zcy >= 0) && (zcx <= d2) && (zcy <= d2) && !zcx[0] && !zcy[0]
             && (zu >= 0) && (zu[1:0] == 2'b00) && (zu[6:2] < {1'b0, cfg.h});

        xu = xcx - 8'sd2 - (xcy[1] ? 8'sd0 : 8'sd2);
        xv = (xcx >= 0) && (xcy >= 0) && (xcx <= d2) && (xcy <= d2) && !xcx[0] && !xcy[0]
             && (xu >= 0) && (xu[1:0] == 2'b00) && (xu[6:2] < {1'b0, cfg.h});

        dv = (dcx >= 8'sd1) && (dcy >= 8'sd1) && (dcx < d2) && (dcy < d2)
             && dcx[0] && dcy[0];

        has4_next  = 1'b0;
        ctl4_next  = 1'b0;
        base4_next = '0;
        ma4_next   = '0;
        mb4_next   = '0;
        ad4_next   = '0;
        case (in_cls)
            QC_DATA: begin
                if (zv) begin
                    has4_next  = 1'b1;
                    ctl4_next  = 1'b1;
                    base4_next = 11'({1'b0, cfg.dd} + {2'b00, cfg.hx});
                    ma4_next   = zcx[5:1];
                    mb4_next   = {2'b00, cfg.h};
                    ad4_next   = zu[6:2];
                end else if (xv) begin
                    has4_next  = 1'b1;
                    base4_next = {1'b0, cfg.dd};
                    ma4_next   = xu[6:2];
                    mb4_next   = 6'({1'b0, cfg.d} + 6'd1);
                    ad4_next   = xcy[5:1];
                end
            end
            QC_XANC, QC_ZANC: begin
                has4_next = dv;
                ctl4_next = dv && (in_cls == QC_XANC);
                ma4_next  = dcx[5:1];
                mb4_next  = {1'b0, cfg.d};
                ad4_next  = dcy[5:1];
            end
            default: begin
                has4_next = 1'b0;
            end
        endcase
        if (in_status != ST_OK) begin
            has4_next = 1'b0;
            ctl4_next = 1'b0;
        end
    end

    assign p5_next = 11'(base4_reg + 11'(ma4_reg * mb4_reg) + {6'd0, ad4_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st4_reg   <= in_status;
            x4_reg    <= (in_status == ST_OK) ? in_x : 6'd0;
            y4_reg    <= (in_status == ST_OK) ? in_y : 6'd0;
            has4_reg  <= has4_next;
            ctl4_reg  <= ctl4_next;
            base4_reg <= base4_next;
            ma4_reg   <= ma4_next;
            mb4_reg   <= mb4_next;
            ad4_reg   <= ad4_next;
            st5_reg   <= st4_reg;
            x5_reg    <= x4_reg;
            y5_reg    <= y4_reg;
            has5_reg  <= has4_reg;
            ctl5_reg  <= ctl4_reg;
            p5_reg    <= has4_reg ? p5_next : 11'd0;
        end
    end

    assign out_valid   = v5_reg;
    assign out_status  = st5_reg;
    assign out_x       = x5_reg;
    assign out_y       = y5_reg;
    assign out_has     = has5_reg;
    assign out_partner = p5_reg;
    assign out_ctl     = ctl5_reg;

endmodule

// ===== src/surface_code_cnot_partner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// surface_code_cnot_partner
// Throughput is one transaction per cycle unless a result waits on m_ready;
// the five stage pipeline stalls as one.
// Reset is synchronous and active low; it empties the pipeline and sets the
// code distance to 3.
// ----------------------------------------------------------------------------
module surface_code_cnot_partner
    import scp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_step,
    input  logic [10:0] s_qubit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [5:0]  m_coord_x,
    output logic [5:0]  m_coord_y,
    output logic        m_has_partner,
    output logic [10:0] m_partner,
    output logic        m_is_control
);

    cfg_t       cfg;
    logic       en;
    logic       dv;
    status_t    dst;
    qclass_t    dcl;
    logic [1:0] dsp;
    logic [5:0] dx, dy;

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    scp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_valid),
        .wr_data (cfg_data),
        .cfg     (cfg)
    );

    scp_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .cfg        (cfg),
        .in_valid   (s_valid),
        .in_step    (s_step),
        .in_qubit   (s_qubit),
        .out_valid  (dv),
        .out_status (dst),
        .out_cls    (dcl),
        .out_step   (dsp),
        .out_x      (dx),
        .out_y      (dy)
    );

    scp_partner u_partner (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .cfg         (cfg),
        .in_valid    (dv),
        .in_status   (dst),
        .in_cls      (dcl),
        .in_step     (dsp),
        .in_x        (dx),
        .in_y        (dy),
        .out_valid   (m_valid),
        .out_status  (m_status),
        .out_x       (m_coord_x),
        .out_y       (m_coord_y),
        .out_has     (m_has_partner),
        .out_partner (m_partner),
        .out_ctl     (m_is_control)
    );

endmodule

// ===== verif/surface_code_cnot_partner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// surface_code_cnot_partner_tb
// Drives qubit lookups through the CNOT partner block under several code
// distances and handshake pressures, and checks every result against a
// behavioral prediction of lattice coordinates and CNOT partners.
// ----------------------------------------------------------------------------
module surface_code_cnot_partner_tb;
    import scp_pkg::*;

    typedef struct {
        status_t     st;
        logic [5:0]  cx;
        logic [5:0]  cy;
        logic        has_p;
        logic [10:0] partner;
        logic        ctl;
    } lookup_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_step = '0;
    logic [10:0] s_qubit = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [5:0]  m_coord_x;
    logic [5:0]  m_coord_y;
    logic        m_has_partner;
    logic [10:0] m_partner;
    logic        m_is_control;

    lookup_t pending_lookups[$];
    int      distance = 3;
    int      src_idle_pct = 0;
    int      snk_stall_pct = 0;
    int      mismatches = 0;
    int      quiet_cycles = 0;

    localparam int QuietLimit = 5000;

    surface_code_cnot_partner DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_step(s_step), .s_qubit(s_qubit),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_coord_x(m_coord_x), .m_coord_y(m_coord_y),
        .m_has_partner(m_has_partner), .m_partner(m_partner),
        .m_is_control(m_is_control)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int data_index(int cx, int cy, int d);
        if (cx < 1 || cy < 1 || cx > 2 * d - 1 || cy > 2 * d - 1) return -1;
        if (cx % 2 == 0 || cy % 2 == 0) return -1;
        return ((cx - 1) / 2) * d + (cy - 1) / 2;
    endfunction

    function automatic lookup_t predict_partner(int d, int s, int q);
        lookup_t r;
        int xdx[4] = '{-1, 1, -1, 1};
        int xdy[4] = '{1, 1, -1, -1};
        int zdx[4] = '{-1, -1, 1, 1};
        int zdy[4] = '{1, -1, 1, -1};
        int dd, hx, h, x, y, p, c, ax, ay, t, k, rr;
        r.st = ST_OK; r.cx = '0; r.cy = '0; r.has_p = 1'b0; r.partner = '0; r.ctl = 1'b0;
        if (d < 3 || d % 2 == 0 || d > MaxDistance) begin
            r.st = ST_DISTANCE;
            return r;
        end
        dd = d * d;
        hx = (dd - 1) / 2;
        h = (d - 1) / 2;
        if (q >= 2 * dd - 1) begin
            r.st = ST_RANGE;
            return r;
        end
        p = -1;
        c = 0;
        if (q < dd) begin
            x = 2 * (q / d) + 1;
            y = 2 * (q % d) + 1;
            ax = x - zdx[s];
            ay = y - zdy[s];
            if (ax >= 0 && ay >= 0 && ax <= 2 * d && ay <= 2 * d && ax % 2 == 0
                    && ay % 2 == 0) begin
                t = ax % 4;
                if (ay >= 2 + t && (ay - 2 - t) % 4 == 0 && (ay - 2 - t) / 4 <= (d - 3) / 2)
                    p = dd + hx + (ax / 2) * h + (ay - 2 - t) / 4;
            end
            if (p >= 0) begin
                c = 1;
            end else begin
                ax = x - xdx[s];
                ay = y - xdy[s];
                if (ax >= 0 && ay >= 0 && ax <= 2 * d && ay <= 2 * d && ax % 2 == 0
                        && ay % 2 == 0) begin
                    t = (ay % 4 == 0) ? 2 : 0;
                    k = (ax - 2 - t) / 4;
                    if (ax >= 2 + t && (ax - 2 - t) % 4 == 0 && k <= (d - 3) / 2)
                        p = dd + k * (d + 1) + ay / 2;
                end
            end
        end else if (q < dd + hx) begin
            rr = q - dd;
            y = 2 * (rr % (d + 1));
            x = 2 + 4 * (rr / (d + 1)) + ((y % 4 == 0) ? 2 : 0);
            p = data_index(x + xdx[s], y + xdy[s], d);
            c = 1;
        end else begin
            rr = q - dd - hx;
            x = 2 * (rr / h);
            y = 2 + 4 * (rr % h) + (x % 4);
            p = data_index(x + zdx[s], y + zdy[s], d);
        end
        r.cx = x[5:0];
        r.cy = y[5:0];
        if (p >= 0) begin
            r.has_p = 1'b1;
            r.partner = p[10:0];
            r.ctl = c[0];
        end
        return r;
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    always @(negedge aclk) begin
        m_ready = aresetn && ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        lookup_t e;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QuietLimit) begin
                $display("CHECKS FAILED");
                $finish;
            end
            if (m_valid && m_ready) begin
                if (pending_lookups.size() == 0) begin
                    mismatches++;
                    $display("%0t: result transaction with no expectation", $time);
                end else begin
                    e = pending_lookups.pop_front();
                    check_field("status", e.st, m_status);
                    check_field("coord_x", e.cx, m_coord_x);
                    check_field("coord_y", e.cy, m_coord_y);
                    check_field("has_partner", e.has_p, m_has_partner);
                    check_field("partner", e.partner, m_partner);
                    check_field("is_control", e.ctl, m_is_control);
                end
            end
        end
    end

    task automatic send_lookup(int s, int q);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_step = s[1:0];
        s_qubit = q[10:0];
        do @(posedge aclk); while (!s_ready);
        pending_lookups.push_back(predict_partner(distance, s, q));
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (pending_lookups.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_distance(int d);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data = d[4:0];
        do @(posedge aclk); while (!cfg_ready);
        distance = d;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Coordinates and partners of every qubit class at distances 3 and 31,
    // including data qubits that see both ancilla types, and out-of-range edges.
    task automatic test_directed();
        int qs[8] = '{0, 4, 8, 9, 12, 13, 16, 17};
        write_distance(3);
        foreach (qs[i])
            for (int s = 0; s < 4; s++) send_lookup(s, qs[i]);
        send_lookup(0, 2047);
        write_distance(31);
        send_lookup(3, 0);
        send_lookup(1, 960);
        send_lookup(2, 961);
        send_lookup(0, 1920);
        send_lookup(1, 1921);
    endtask

    task automatic test_bad_distance();
        int bad[6] = '{0, 1, 2, 4, 30, 16};
        foreach (bad[i]) begin
            write_distance(bad[i]);
            send_lookup($urandom_range(3), $urandom_range(2047));
            send_lookup($urandom_range(3), 0);
        end
    endtask

    task automatic test_random();
        int idle[4] = '{0, 66, 0, 27};
        int stall[4] = '{0, 0, 66, 27};
        int d, lim;
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct = idle[ph];
            snk_stall_pct = stall[ph];
            for (int chunk = 0; chunk < 4; chunk++) begin
                if (chunk == 0) d = 31;
                else if ($urandom_range(9) == 0) d = 2 * $urandom_range(15);
                else d = 2 * $urandom_range(1, 15) + 1;
                write_distance(d);
                lim = (d >= 3) ? 2 * d * d - 2 : 2047;
                for (int n = 0; n < 110; n++) begin
                    if (n == 55 && ph == 3) wait_drained();
                    if ($urandom_range(9) == 0)
                        send_lookup($urandom_range(3), $urandom_range(2047));
                    else
                        send_lookup($urandom_range(3), $urandom_range(lim));
                end
            end
        end
        src_idle_pct = 0;
        snk_stall_pct = 0;
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed();
        test_bad_distance();
        test_random();
        s_valid = 1'b0;
        while (pending_lookups.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
